// ===== sv/pngu_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter and gray converter.
`timescale 1ns / 1ps
package pngu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;
    localparam logic [1:0] CFG_WIDE   = 2'd3;

    // Color modes.
    localparam logic [1:0] MODE_GRAY  = 2'd0;
    localparam logic [1:0] MODE_RGB   = 2'd1;
    localparam logic [1:0] MODE_GA    = 2'd2;
    localparam logic [1:0] MODE_RGBA  = 2'd3;

    // Filter types; anything above Paeth is held as the pass-through code.
    localparam logic [2:0] FLT_NONE   = 3'd0;
    localparam logic [2:0] FLT_SUB    = 3'd1;
    localparam logic [2:0] FLT_UP     = 3'd2;
    localparam logic [2:0] FLT_AVG    = 3'd3;
    localparam logic [2:0] FLT_PAETH  = 3'd4;
    localparam logic [2:0] FLT_PASS   = 3'd5;

    // Luma weights in Q16.
    localparam logic [15:0] LUMA_KR = 16'd19595;
    localparam logic [15:0] LUMA_KG = 16'd38470;
    localparam logic [15:0] LUMA_KB = 16'd7471;

    // Row byte count arithmetic width (covers the largest row byte limit).
    localparam int ROWB_W = 20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // input transaction accepted
        logic       recon;     // reconstruct the sample byte and update state
        logic       lum;       // one luma multiply-accumulate step
        logic [1:0] lum_idx;   // channel used by the luma step
        logic       blend;     // form the alpha blend product
        logic       fin;       // form the final gray level
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic expect_filter;   // next byte is a filter-type byte
        logic pix_done;        // byte under reconstruction completes a pixel
    } t_sts;

endpackage

// ===== sv/pngu_ctrl.sv =====
// Controller state machine for the PNG unfilter: sequences load, reconstruction and gray steps.
`timescale 1ns / 1ps
module pngu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  pngu_pkg::t_sts i_sts,
    output pngu_pkg::t_cmd o_cmd
);
    import pngu_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RECON = 8'b0000_0010,
        S_LUM0  = 8'b0000_0100,
        S_LUM1  = 8'b0000_1000,
        S_LUM2  = 8'b0001_0000,
        S_BLEND = 8'b0010_0000,
        S_FINAL = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.expect_filter ? S_IDLE : S_RECON;
                end
            end
            S_RECON: begin
                o_cmd.recon = 1'b1;
                n_state = i_sts.pix_done ? S_LUM0 : S_OUT;
            end
            S_LUM0: begin
                o_cmd.lum = 1'b1;
                o_cmd.lum_idx = 2'd0;
                n_state = S_LUM1;
            end
            S_LUM1: begin
                o_cmd.lum = 1'b1;
                o_cmd.lum_idx = 2'd1;
                n_state = S_LUM2;
            end
            S_LUM2: begin
                o_cmd.lum = 1'b1;
                o_cmd.lum_idx = 2'd2;
                n_state = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

`ifndef SYNTHESIS
    // A new input transaction never lands while a result is still offered.
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a result is pending");

    // An accepted input leaves no result visible in the next cycle.
    a_accept_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result offered right after an input transaction");

    // A result only appears after reconstruction or the final gray step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_RECON || $past(r_state) == S_FINAL))
        else $error("result raised from an unexpected state");

    // A completed pixel always runs the gray steps before its result shows.
    a_pix_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RECON && i_sts.pix_done) |=> (r_state == S_LUM0))
        else $error("pixel completion skipped the gray steps");
`endif

endmodule

// ===== sv/pngu_dp.sv =====
// Datapath for the PNG unfilter: config registers, line store, filters and gray conversion.
`timescale 1ns / 1ps
module pngu_dp #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_ROW_BYTES = 32768
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic [7:0]     i_raw_byte,
    input  pngu_pkg::t_cmd i_cmd,
    output pngu_pkg::t_sts o_sts,
    output logic [7:0]     o_recon_byte,
    output logic           o_pixel_done,
    output logic [7:0]     o_gray_level,
    output logic           o_row_last,
    output logic           o_image_last
);
    import pngu_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);

    // Configuration.
    logic [12:0] r_width;
    logic [15:0] r_height;
    logic [1:0]  r_mode;
    logic        r_wide;

    // Scan state.
    logic          r_expect;
    logic [2:0]    r_filter;
    logic [AW-1:0] r_x;
    logic [1:0]    r_m3;
    logic [15:0]   r_row_cnt;
    logic          r_first;
    logic [7:0]    r_left [8];
    logic [7:0]    r_ul   [8];
    logic [7:0]    r_chan [4];

    logic [7:0] r_v;
    logic [7:0] r_mem_q;
    logic [7:0] r_mem [MAX_ROW_BYTES];

    // Gray pipeline.
    logic [23:0] r_acc;
    logic [15:0] r_prod;
    logic [7:0]  r_bl_v;

    // Result register.
    logic [7:0] r_out_recon, r_out_gray;
    logic       r_out_done, r_out_rlast, r_out_ilast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 16'd1;
            r_mode   <= MODE_GRAY;
            r_wide   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_WIDE:   r_wide   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Geometry derived from configuration.
    logic [2:0]        chan;
    logic [3:0]        bpp;
    logic [12:0]       w_eff;
    logic [ROWB_W-1:0] rb_raw, row_bytes;
    logic [15:0]       height;

    always_comb begin
        case (r_mode)
            MODE_GRAY: chan = 3'd1;
            MODE_RGB:  chan = 3'd3;
            MODE_GA:   chan = 3'd2;
            default:   chan = 3'd4;
        endcase
        bpp = {1'b0, chan} << r_wide;
        if (r_width == 13'd0) begin
            w_eff = 13'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        rb_raw = ROWB_W'(w_eff) * ROWB_W'(bpp);
        if (32'(rb_raw) > MAX_ROW_BYTES) begin
            row_bytes = ROWB_W'(MAX_ROW_BYTES);
        end else begin
            row_bytes = rb_raw;
        end
        height = (r_height == 16'd0) ? 16'd1 : r_height;
    end

    // Byte position within the pixel, from the column and its residue mod 3.
    logic [2:0] pos;
    logic       pix_nz;
    logic       done;
    logic       rlast;

    always_comb begin
        case (bpp)
            4'd2:    pos = {2'b00, r_x[0]};
            4'd3:    pos = {1'b0, r_m3};
            4'd4:    pos = {1'b0, r_x[1:0]};
            4'd6:    pos = (r_m3[0] == r_x[0]) ? {1'b0, r_m3} : ({1'b0, r_m3} + 3'd3);
            4'd8:    pos = r_x[2:0];
            default: pos = 3'd0;
        endcase
        pix_nz = ROWB_W'(r_x) >= ROWB_W'(bpp);
        done   = ({1'b0, pos} == (bpp - 4'd1));
        rlast  = (ROWB_W'(r_x) + ROWB_W'(1)) >= row_bytes;
    end

    // Filter reconstruction.
    logic [7:0] a, b, c, pred, recon;
    logic [9:0] p, pa, pb, pc;
    logic [8:0] avg_sum;

    always_comb begin
        a = pix_nz ? r_left[pos] : 8'd0;
        b = r_first ? 8'd0 : r_mem_q;
        c = (pix_nz && !r_first) ? r_ul[pos] : 8'd0;
        p  = {2'b00, a} + {2'b00, b} - {2'b00, c};
        pa = ($signed(p) >= $signed({2'b00, a})) ? p - {2'b00, a} : {2'b00, a} - p;
        pb = ($signed(p) >= $signed({2'b00, b})) ? p - {2'b00, b} : {2'b00, b} - p;
        pc = ($signed(p) >= $signed({2'b00, c})) ? p - {2'b00, c} : {2'b00, c} - p;
        avg_sum = {1'b0, a} + {1'b0, b};
        case (r_filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH: pred = (pa <= pb && pa <= pc) ? a : ((pb <= pc) ? b : c);
            default:   pred = 8'd0;
        endcase
        recon = r_v + pred;
    end

    // Line store of the prior row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_q <= r_mem[r_x];
        end
        if (i_cmd.recon) begin
            r_mem[r_x] <= recon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect  <= 1'b1;
            r_filter  <= FLT_NONE;
            r_x       <= '0;
            r_m3      <= 2'd0;
            r_row_cnt <= 16'd0;
            r_first   <= 1'b1;
            for (int i = 0; i < 8; i++) begin
                r_left[i] <= 8'd0;
                r_ul[i]   <= 8'd0;
            end
            for (int i = 0; i < 4; i++) begin
                r_chan[i] <= 8'd0;
            end
        end else begin
            if (i_cmd.load && r_expect) begin
                r_filter <= (i_raw_byte > 8'd4) ? FLT_PASS : i_raw_byte[2:0];
                r_expect <= 1'b0;
            end
            if (i_cmd.recon) begin
                r_ul[pos]   <= b;
                r_left[pos] <= recon;
                if ((pos[0] & r_wide) == 1'b0) begin
                    r_chan[2'(pos >> r_wide)] <= recon;
                end
                if (rlast) begin
                    r_expect <= 1'b1;
                    r_x      <= '0;
                    r_m3     <= 2'd0;
                    if ({1'b0, r_row_cnt} + 17'd1 >= {1'b0, height}) begin
                        r_row_cnt <= 16'd0;
                        r_first   <= 1'b1;
                    end else begin
                        r_row_cnt <= r_row_cnt + 16'd1;
                        r_first   <= 1'b0;
                    end
                end else begin
                    r_x  <= r_x + AW'(1);
                    r_m3 <= (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
                end
            end
        end
    end

    // Input byte and gray arithmetic (payload, no reset).
    logic [7:0]  lum_h;
    logic [15:0] lum_k;
    logic [7:0]  bl_a, bl_v;
    logic [16:0] div_sum;
    logic [7:0]  blended;

    always_comb begin
        case (i_cmd.lum_idx)
            2'd0:    begin lum_h = r_chan[0]; lum_k = LUMA_KR; end
            2'd1:    begin lum_h = r_chan[1]; lum_k = LUMA_KG; end
            default: begin lum_h = r_chan[2]; lum_k = LUMA_KB; end
        endcase
        bl_v = (r_mode == MODE_GA) ? r_chan[0] : r_acc[23:16];
        bl_a = (r_mode == MODE_GA) ? r_chan[1] : r_chan[3];
        // Exact divide by 255 for products below 65280.
        div_sum = {1'b0, r_prod} + {9'd0, r_prod[15:8]} + 17'd1;
        blended = r_bl_v + div_sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_raw_byte;
        end
        if (i_cmd.lum) begin
            r_acc <= ((i_cmd.lum_idx == 2'd0) ? 24'd0 : r_acc)
                     + 24'(lum_k) * 24'(lum_h);
        end
        if (i_cmd.blend) begin
            r_prod <= 16'(8'd255 - bl_a) * 16'(8'd255 - bl_v);
            r_bl_v <= bl_v;
        end
        if (i_cmd.recon) begin
            r_out_recon <= recon;
            r_out_done  <= done;
            r_out_gray  <= 8'd0;
            r_out_rlast <= rlast;
            r_out_ilast <= rlast && ({1'b0, r_row_cnt} + 17'd1 >= {1'b0, height});
        end
        if (i_cmd.fin) begin
            case (r_mode)
                MODE_GRAY: r_out_gray <= r_chan[0];
                MODE_RGB:  r_out_gray <= r_acc[23:16];
                default:   r_out_gray <= blended;
            endcase
        end
    end

    assign o_sts.expect_filter = r_expect;
    assign o_sts.pix_done      = done;
    assign o_recon_byte = r_out_recon;
    assign o_pixel_done = r_out_done;
    assign o_gray_level = r_out_gray;
    assign o_row_last   = r_out_rlast;
    assign o_image_last = r_out_ilast;

endmodule

// ===== sv/png_unfilter_to_gray.sv =====
// Top level of the PNG scanline unfilter with conversion to 8-bit gray.
//
//  channel  valid     stall     payload
//  input    i_valid   o_stall   i_raw_byte
//  output   o_valid   i_stall   o_recon_byte o_pixel_done o_gray_level o_row_last o_image_last
//  config   i_cfg_we  -         i_cfg_idx i_cfg_data
//
// A filter-type byte is taken in the idle state with no result. A sample byte goes through
// load with line store read, reconstruct and present to its result; one that completes a
// pixel also runs three luma multiply steps on one shared multiplier and two blend steps
// for the gray level before present. One byte is in flight at a time; the next input
// transaction is taken in the cycle after its result transaction. Reset is synchronous,
// active low, and needs no clearing pass; the line store is only used where a row was written.
`timescale 1ns / 1ps
module png_unfilter_to_gray #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_ROW_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_raw_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_recon_byte,
    output logic        o_pixel_done,
    output logic [7:0]  o_gray_level,
    output logic        o_row_last,
    output logic        o_image_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import pngu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pngu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pngu_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_raw_byte   (i_raw_byte),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_recon_byte (o_recon_byte),
        .o_pixel_done (o_pixel_done),
        .o_gray_level (o_gray_level),
        .o_row_last   (o_row_last),
        .o_image_last (o_image_last)
    );

endmodule
